@@ src/dsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants for the delta sample channel
// Opcodes, register indexes, rate periods and the structs that pass between
// the configuration registers, the channel core and the output stage.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned TIMER_W = 9;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned BITS_W  = 4;

  localparam logic [ADDR_W-1:0]  START_BASE   = 16'hC000;
  localparam logic [ADDR_W-1:0]  WRAP_BASE    = 16'h8000;
  localparam logic [LEVEL_W-1:0] LEVEL_UP_MAX = 7'd125;
  localparam logic [LEVEL_W-1:0] LEVEL_DN_MIN = 7'd2;
  localparam logic [BITS_W-1:0]  BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_DELIVER = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_INDEX = 3'd0,
    REG_LOOP_EN    = 3'd1,
    REG_IRQ_EN     = 3'd2,
    REG_START_ADDR = 3'd3,
    REG_LENGTH     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] rate_index;
    logic       loop_enable;
    logic       irq_enable;
    logic [7:0] start_address_reg;
    logic [7:0] length_reg;
    logic       irq_clear;   // write of zero to the irq enable, this cycle
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               irq;
    logic               fetch_request;
    logic [ADDR_W-1:0]  fetch_address;
  } result_t;

  // timer period table, expiry once the count passes this value
  function automatic logic [TIMER_W-1:0] rate_period(input logic [3:0] idx);
    logic [TIMER_W-1:0] p;
    unique case (idx)
      4'd0:  p = 9'd428;
      4'd1:  p = 9'd380;
      4'd2:  p = 9'd340;
      4'd3:  p = 9'd320;
      4'd4:  p = 9'd286;
      4'd5:  p = 9'd254;
      4'd6:  p = 9'd226;
      4'd7:  p = 9'd214;
      4'd8:  p = 9'd190;
      4'd9:  p = 9'd160;
      4'd10: p = 9'd142;
      4'd11: p = 9'd128;
      4'd12: p = 9'd106;
      4'd13: p = 9'd84;
      4'd14: p = 9'd72;
      4'd15: p = 9'd54;
      default: p = 9'd428;
    endcase
    return p;
  endfunction

endpackage

@@ src/dsc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_in_if: request channel into the delta sample channel
// Valid/ready handshake carrying an opcode and a fetched sample byte.
// ----------------------------------------------------------------------------
interface dsc_in_if;
  import dsc_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] fetched_byte;

  modport source (output valid, output opcode, output fetched_byte, input ready);
  modport sink   (input valid, input opcode, input fetched_byte, output ready);
endinterface

@@ src/dsc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_out_if: result channel out of the delta sample channel
// Valid/ready handshake carrying level, irq and the fetch request.
// ----------------------------------------------------------------------------
interface dsc_out_if;
  import dsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               irq;
  logic               fetch_request;
  logic [ADDR_W-1:0]  fetch_address;

  modport source (output valid, output level, output irq, output fetch_request,
                  output fetch_address, input ready);
  modport sink   (input valid, input level, input irq, input fetch_request,
                  input fetch_address, output ready);
endinterface

@@ src/dsc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_cfg_regs: configuration register file
// Write-only registers; bits above each register's width are dropped and
// writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
module dsc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  output dsc_pkg::cfg_t                    cfg
);
  import dsc_pkg::*;

  logic [3:0] rate_index_r;
  logic       loop_enable_r;
  logic       irq_enable_r;
  logic [7:0] start_address_r;
  logic [7:0] length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_index_r    <= '0;
      loop_enable_r   <= 1'b0;
      irq_enable_r    <= 1'b0;
      start_address_r <= '0;
      length_r        <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RATE_INDEX: rate_index_r    <= cfg_wr_data[3:0];
        REG_LOOP_EN:    loop_enable_r   <= cfg_wr_data[0];
        REG_IRQ_EN:     irq_enable_r    <= cfg_wr_data[0];
        REG_START_ADDR: start_address_r <= cfg_wr_data;
        REG_LENGTH:     length_r        <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rate_index        = rate_index_r;
    cfg.loop_enable       = loop_enable_r;
    cfg.irq_enable        = irq_enable_r;
    cfg.start_address_reg = start_address_r;
    cfg.length_reg        = length_r;
    // disabling the interrupt also drops a pending flag
    cfg.irq_clear         = cfg_wr_en && (cfg_index == REG_IRQ_EN) && !cfg_wr_data[0];
  end

endmodule

@@ src/dsc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_core: channel state and its per-request update
// Rate timer, output unit, sample buffer and fetch sequencing. The whole
// update for one request is settled in the cycle it is accepted.
// ----------------------------------------------------------------------------
module dsc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [1:0]       opcode,
  input  logic [7:0]       fetched_byte,
  input  dsc_pkg::cfg_t    cfg,
  output dsc_pkg::result_t result
);
  import dsc_pkg::*;

  logic [TIMER_W-1:0] rate_timer_r,  rate_timer_nxt;
  logic [LEVEL_W-1:0] level_r,       level_nxt;
  logic [7:0]         shifter_r,     shifter_nxt;
  logic [BITS_W-1:0]  bits_left_r,   bits_left_nxt;
  logic               silent_r,      silent_nxt;
  logic [7:0]         buffer_r,      buffer_nxt;
  logic               buffer_full_r, buffer_full_nxt;
  logic               pending_r,     pending_nxt;
  logic [ADDR_W-1:0]  address_r,     address_nxt;
  logic [COUNT_W-1:0] bytes_left_r,  bytes_left_nxt;
  logic               irq_r,         irq_nxt;

  logic [TIMER_W-1:0] timer_inc;
  logic [ADDR_W-1:0]  start_addr;
  logic [COUNT_W-1:0] start_count;
  logic [ADDR_W-1:0]  addr_inc;
  logic [COUNT_W-1:0] count_dec;
  logic [BITS_W-1:0]  bits_dec;

  assign timer_inc   = rate_timer_r + TIMER_W'(1);
  assign start_addr  = START_BASE + {2'b00, cfg.start_address_reg, 6'b000000};
  assign start_count = {cfg.length_reg, 4'b0001};
  assign addr_inc    = address_r + ADDR_W'(1);
  assign count_dec   = (bytes_left_r != '0) ? bytes_left_r - COUNT_W'(1) : bytes_left_r;
  assign bits_dec    = bits_left_r - BITS_W'(1);

  always_comb begin
    rate_timer_nxt  = rate_timer_r;
    level_nxt       = level_r;
    shifter_nxt     = shifter_r;
    bits_left_nxt   = bits_left_r;
    silent_nxt      = silent_r;
    buffer_nxt      = buffer_r;
    buffer_full_nxt = buffer_full_r;
    pending_nxt     = pending_r;
    address_nxt     = address_r;
    bytes_left_nxt  = bytes_left_r;
    irq_nxt         = irq_r;

    unique case (opcode_t'(opcode))
      OP_TICK: begin
        if (timer_inc > rate_period(cfg.rate_index)) begin
          rate_timer_nxt = '0;
          if (!silent_r) begin
            if (shifter_r[0]) begin
              if (level_r <= LEVEL_UP_MAX) level_nxt = level_r + LEVEL_W'(2);
            end else begin
              if (level_r >= LEVEL_DN_MIN) level_nxt = level_r - LEVEL_W'(2);
            end
          end
          shifter_nxt   = {1'b0, shifter_r[7:1]};
          bits_left_nxt = bits_dec;
          // end of a byte: reload from the buffer or fall silent
          if (bits_dec == '0) begin
            bits_left_nxt = BITS_PER_BYTE;
            if (buffer_full_r) begin
              silent_nxt      = 1'b0;
              shifter_nxt     = buffer_r;
              buffer_full_nxt = 1'b0;
            end else begin
              silent_nxt = 1'b1;
            end
          end
        end else begin
          rate_timer_nxt = timer_inc;
        end
      end
      OP_ENABLE: begin
        irq_nxt = 1'b0;
        if (bytes_left_r == '0) begin
          address_nxt    = start_addr;
          bytes_left_nxt = start_count;
        end
      end
      OP_DISABLE: begin
        irq_nxt        = 1'b0;
        bytes_left_nxt = '0;
        pending_nxt    = 1'b0;
      end
      OP_DELIVER: begin
        // a byte nobody asked for is dropped
        if (pending_r) begin
          pending_nxt     = 1'b0;
          buffer_nxt      = fetched_byte;
          buffer_full_nxt = 1'b1;
          address_nxt     = (addr_inc == '0) ? WRAP_BASE : addr_inc;
          bytes_left_nxt  = count_dec;
          if (count_dec == '0) begin
            if (cfg.loop_enable) begin
              address_nxt    = start_addr;
              bytes_left_nxt = start_count;
            end else if (cfg.irq_enable) begin
              irq_nxt = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    if (!buffer_full_nxt && (bytes_left_nxt != '0) && !pending_nxt) pending_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_timer_r  <= '0;
      level_r       <= '0;
      shifter_r     <= '0;
      bits_left_r   <= BITS_PER_BYTE;
      silent_r      <= 1'b1;
      buffer_r      <= '0;
      buffer_full_r <= 1'b0;
      pending_r     <= 1'b0;
      address_r     <= START_BASE;
      bytes_left_r  <= '0;
      irq_r         <= 1'b0;
    end else if (accept) begin
      rate_timer_r  <= rate_timer_nxt;
      level_r       <= level_nxt;
      shifter_r     <= shifter_nxt;
      bits_left_r   <= bits_left_nxt;
      silent_r      <= silent_nxt;
      buffer_r      <= buffer_nxt;
      buffer_full_r <= buffer_full_nxt;
      pending_r     <= pending_nxt;
      address_r     <= address_nxt;
      bytes_left_r  <= bytes_left_nxt;
      irq_r         <= irq_nxt;
    end else if (cfg.irq_clear) begin
      irq_r <= 1'b0;
    end
  end

  always_comb begin
    result.level         = level_nxt;
    result.irq           = irq_nxt;
    result.fetch_request = pending_nxt;
    result.fetch_address = pending_nxt ? address_nxt : '0;
  end

endmodule

@@ src/dsc_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_out_stage: result register
// Holds one result until taken; a new request is accepted whenever the
// register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module dsc_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dsc_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output dsc_pkg::result_t out_res
);
  import dsc_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res;
    end
  end

endmodule

@@ src/dpcm_sample_channel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcm_sample_channel: one-bit delta sample channel
// Rate timer, 7-bit output level, sample buffer and memory fetch sequencing,
// driven by tick / enable / disable / byte-delivered requests.
// ----------------------------------------------------------------------------
// Every accepted request returns exactly one result (level, irq, fetch
// request and address) from a result register in the next cycle. A request
// may be accepted each cycle, so the channel sustains one request per clock;
// it stalls only while the result register holds a result that the sink has
// not taken. The whole state update is a single pass of logic between the
// state registers and the result register. Configuration writes take effect
// at once and are meant to be made while no request is in flight; writing
// zero to the irq enable also clears a pending interrupt.
module dpcm_sample_channel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  dsc_in_if.sink                         in_ch,
  dsc_out_if.source                      out_ch
);
  import dsc_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    in_ready;
  logic    accept;

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  dsc_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .cfg        (cfg)
  );

  dsc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .opcode      (in_ch.opcode),
    .fetched_byte(in_ch.fetched_byte),
    .cfg         (cfg),
    .result      (res)
  );

  dsc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .res      (res),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_res  (out_res)
  );

  assign out_ch.level         = out_res.level;
  assign out_ch.irq           = out_res.irq;
  assign out_ch.fetch_request = out_res.fetch_request;
  assign out_ch.fetch_address = out_res.fetch_address;

endmodule

@@ src/dsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_checker: port-level checks for the delta sample channel
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module dsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  level,
  input logic        fetch_request,
  input logic [15:0] fetch_address
);

  // an accepted request always has its result waiting next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // back-pressure only when a result is stuck in the register
  a_ready_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request side stalled with nothing held");

  // level moves in steps of two from zero
  a_level_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !level[0])
    else $error("odd output level");

  a_addr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !fetch_request |-> fetch_address == 16'h0000)
    else $error("fetch address shown without a fetch request");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(fetch_address))
    else $error("stalled result changed");

endmodule

bind dpcm_sample_channel dsc_checker u_dsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .level        (out_ch.level),
  .fetch_request(out_ch.fetch_request),
  .fetch_address(out_ch.fetch_address)
);
